// ===== hdl/lav_pkg.sv =====
// shared types, widths and step functions for the look-at view matrix pipeline
`timescale 1ns / 1ps
package lav_pkg;

  localparam int FRAC_BITS = 16;
  localparam int IN_W      = 24;
  localparam int ROT_W     = 18;
  localparam int TR_W      = 26;
  localparam int VEC_W     = 42;
  localparam int MAG_W     = VEC_W - 1;
  localparam int NORM_W    = 30;
  localparam int SHW       = 6;
  localparam int SQR_W     = 2 * NORM_W;
  localparam int SUM_W     = SQR_W + 2;
  localparam int SQ_X_W    = 64;
  localparam int SQ_R_W    = 35;
  localparam int SQ_Q_W    = 32;
  localparam int SQ_STG    = SQ_X_W / 4;
  localparam int DIV_STG   = (FRAC_BITS + 3) / 2;
  localparam int DIV_N     = 2 * DIV_STG;
  localparam int DIVD_W    = NORM_W + FRAC_BITS + 1;
  localparam int DR_W      = SQ_Q_W + 1;
  localparam int PROD_W    = IN_W + ROT_W;
  localparam int DOT_W     = PROD_W + 2;

  typedef logic signed [IN_W-1:0]  in_t;
  typedef logic signed [ROT_W-1:0] rot_t;
  typedef logic signed [TR_W-1:0]  tr_t;
  typedef logic signed [VEC_W-1:0] vec_t;

  typedef struct packed {
    in_t  [2:0] eye;
    in_t  [2:0] up;
    rot_t [2:0] w;
    rot_t [2:0] u;
    logic       ok;
  } side_t;

  typedef struct packed {
    logic [SQ_X_W-1:0] x;
    logic [SQ_R_W-1:0] rem;
    logic [SQ_Q_W-1:0] root;
  } sq_t;

  typedef struct packed {
    logic [DR_W-1:0]  rem;
    logic [DIV_N-1:0] d;
    logic [DIV_N-1:0] q;
  } dv_t;

  // two digits of the bit-pair square root
  function automatic sq_t sqrt_step2(sq_t s);
    sq_t              r;
    logic [SQ_R_W-1:0] trial;
    r = s;
    for (int i = 0; i < 2; i++) begin
      r.rem = {r.rem[SQ_R_W-3:0], r.x[SQ_X_W-1:SQ_X_W-2]};
      r.x   = {r.x[SQ_X_W-3:0], 2'b00};
      trial = SQ_R_W'({r.root, 2'b01});
      if (r.rem >= trial) begin
        r.rem  = r.rem - trial;
        r.root = {r.root[SQ_Q_W-2:0], 1'b1};
      end else begin
        r.root = {r.root[SQ_Q_W-2:0], 1'b0};
      end
    end
    return r;
  endfunction

  // two quotient bits of restoring division
  function automatic dv_t div_step2(dv_t v, logic [SQ_Q_W-1:0] n);
    dv_t           r;
    logic [DR_W-1:0] nn;
    r  = v;
    nn = {1'b0, n};
    for (int i = 0; i < 2; i++) begin
      r.rem = {r.rem[DR_W-2:0], r.d[DIV_N-1]};
      r.d   = {r.d[DIV_N-2:0], 1'b0};
      if (r.rem >= nn) begin
        r.rem = r.rem - nn;
        r.q   = {r.q[DIV_N-2:0], 1'b1};
      end else begin
        r.q   = {r.q[DIV_N-2:0], 1'b0};
      end
    end
    return r;
  endfunction

endpackage

// ===== hdl/look_at_view_matrix.sv =====
// throughput: one item per cycle while the output is not stalled;
//   three 32-stage normalizers set the depth,
//   each built around a 16-stage square root and a 9-stage divider
// the whole pipeline holds in place while the output is stalled
// reset clears all valid bits; data registers are not reset
`timescale 1ns / 1ps
module look_at_view_matrix (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // eye_x, eye_y, eye_z, up_x, up_y, up_z
  input  logic [143:0] s_axis_tdata,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // right_x/y/z, vert_x/y/z, back_x/y/z, shift_x/y/z
  output logic [239:0] m_axis_tdata
);

  logic                          en;
  lav_pkg::vec_t  [2:0]          eye_vec;
  lav_pkg::side_t                side0;

  logic                          n1_valid, n1_ok;
  lav_pkg::rot_t  [2:0]          n1_vec;
  lav_pkg::side_t                n1_side, side1;

  logic                          c1_valid;
  lav_pkg::vec_t  [2:0]          c1_vec;
  lav_pkg::side_t                c1_side;

  logic                          n2_valid, n2_ok;
  lav_pkg::rot_t  [2:0]          n2_vec;
  lav_pkg::side_t                n2_side, side2;
  lav_pkg::in_t   [2:0]          w_ext;

  logic                          c2_valid;
  lav_pkg::vec_t  [2:0]          c2_vec;
  lav_pkg::side_t                c2_side;

  logic                          n3_valid, n3_ok;
  lav_pkg::rot_t  [2:0]          n3_vec;
  lav_pkg::side_t                n3_side;
  lav_pkg::rot_t  [2:0][2:0]     rows;

  logic                          d_valid, d_ok;
  lav_pkg::rot_t  [2:0][2:0]     d_rows;
  lav_pkg::tr_t   [2:0]          d_shift;

  lav_pkg::rot_t  [2:0][2:0]     o_rot;
  lav_pkg::tr_t   [2:0]          o_shift;

  assign en            = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = en;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      side0.eye[i] = s_axis_tdata[i*lav_pkg::IN_W +: lav_pkg::IN_W];
      side0.up[i]  = s_axis_tdata[(i+3)*lav_pkg::IN_W +: lav_pkg::IN_W];
      eye_vec[i]   = lav_pkg::VEC_W'(side0.eye[i]);
    end
    side0.w  = '0;
    side0.u  = '0;
    side0.ok = 1'b1;
  end

  lav_norm u_norm_w (
    .clk(clk), .rst(rst), .en(en), .in_valid(s_axis_tvalid),
    .in_vec(eye_vec), .in_side(side0),
    .out_valid(n1_valid), .out_vec(n1_vec), .out_ok(n1_ok), .out_side(n1_side)
  );

  always_comb begin
    side1    = n1_side;
    side1.w  = n1_vec;
    side1.ok = n1_ok;
  end

  lav_cross u_cross_u (
    .clk(clk), .rst(rst), .en(en), .in_valid(n1_valid),
    .a(side1.up), .b(n1_vec), .in_side(side1),
    .out_valid(c1_valid), .out_vec(c1_vec), .out_side(c1_side)
  );

  lav_norm u_norm_u (
    .clk(clk), .rst(rst), .en(en), .in_valid(c1_valid),
    .in_vec(c1_vec), .in_side(c1_side),
    .out_valid(n2_valid), .out_vec(n2_vec), .out_ok(n2_ok), .out_side(n2_side)
  );

  always_comb begin
    side2    = n2_side;
    side2.u  = n2_vec;
    side2.ok = n2_side.ok && n2_ok;
    for (int i = 0; i < 3; i++) begin
      w_ext[i] = lav_pkg::IN_W'(n2_side.w[i]);
    end
  end

  lav_cross u_cross_v (
    .clk(clk), .rst(rst), .en(en), .in_valid(n2_valid),
    .a(w_ext), .b(n2_vec), .in_side(side2),
    .out_valid(c2_valid), .out_vec(c2_vec), .out_side(c2_side)
  );

  lav_norm u_norm_v (
    .clk(clk), .rst(rst), .en(en), .in_valid(c2_valid),
    .in_vec(c2_vec), .in_side(c2_side),
    .out_valid(n3_valid), .out_vec(n3_vec), .out_ok(n3_ok), .out_side(n3_side)
  );

  always_comb begin
    rows[0] = n3_side.u;
    rows[1] = n3_vec;
    rows[2] = n3_side.w;
  end

  lav_dot u_dot (
    .clk(clk), .rst(rst), .en(en), .in_valid(n3_valid),
    .in_rows(rows), .eye(n3_side.eye), .in_ok(n3_side.ok && n3_ok),
    .out_valid(d_valid), .out_rows(d_rows), .out_shift(d_shift), .out_ok(d_ok)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (en) begin
      m_axis_tvalid <= d_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      o_rot   <= d_ok ? d_rows : '0;
      o_shift <= d_ok ? d_shift : '0;
    end
  end

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        m_axis_tdata[(r*3+c)*lav_pkg::ROT_W +: lav_pkg::ROT_W] = o_rot[r][c];
      end
      m_axis_tdata[9*lav_pkg::ROT_W + r*lav_pkg::TR_W +: lav_pkg::TR_W] = o_shift[r];
    end
  end

`ifndef NO_ASSERTIONS
  localparam int ONE = 1 << lav_pkg::FRAC_BITS;

  a_reset_clears: assert property (@(posedge clk) rst |=> !m_axis_tvalid)
    else $error("output valid after reset");

  a_degenerate_zero: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && o_rot[2] == '0 |-> o_shift == '0)
    else $error("translation not zero for degenerate camera");

  a_unit_range: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> o_rot[0][0] <= ONE && o_rot[0][0] >= -ONE
                   && o_rot[2][2] <= ONE && o_rot[2][2] >= -ONE)
    else $error("rotation component out of unit range");
`endif

endmodule

// ===== hdl/lav_norm.sv =====
// pipelined vector normalizer: scale, sum of squares, square root, divide
`timescale 1ns / 1ps
module lav_norm (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         en,
  input  logic                         in_valid,
  input  lav_pkg::vec_t  [2:0]         in_vec,
  input  lav_pkg::side_t               in_side,
  output logic                         out_valid,
  output lav_pkg::rot_t  [2:0]         out_vec,
  output logic                         out_ok,
  output lav_pkg::side_t               out_side
);

  typedef struct packed {
    lav_pkg::side_t                          side;
    logic [2:0]                              sgn;
    logic                                    zero;
    logic [2:0][lav_pkg::NORM_W-1:0]         m;
  } carry_t;

  logic                                 a_valid;
  lav_pkg::side_t                       a_side;
  logic [2:0]                           a_sgn;
  logic [2:0][lav_pkg::MAG_W-1:0]       a_mag;
  logic [2:0][lav_pkg::MAG_W-1:0]       a_mag_next;

  logic                                 b_valid;
  lav_pkg::side_t                       b_side;
  logic [2:0]                           b_sgn;
  logic [2:0][lav_pkg::MAG_W-1:0]       b_mag;
  logic [lav_pkg::SHW-1:0]              b_p;
  logic                                 b_zero;
  logic [lav_pkg::MAG_W-1:0]            or_all;
  logic [lav_pkg::SHW-1:0]              p_next;

  logic                                 c_valid;
  carry_t                               c_cr;
  logic [2:0][lav_pkg::NORM_W-1:0]      m_next;

  logic                                 d_valid;
  carry_t                               d_cr;
  logic [2:0][lav_pkg::SQR_W-1:0]       d_sq;

  logic                                 e_valid;
  carry_t                               e_cr;
  logic [lav_pkg::SQ_X_W-1:0]           e_x;

  logic   [lav_pkg::SQ_STG-1:0]         f_valid;
  carry_t [lav_pkg::SQ_STG-1:0]         f_cr;
  lav_pkg::sq_t [lav_pkg::SQ_STG-1:0]   f_sq;

  logic                                 g_valid;
  carry_t                               g_cr;
  logic [lav_pkg::SQ_Q_W-1:0]           g_n;
  logic [2:0][lav_pkg::DIVD_W-1:0]      g_d;

  logic   [lav_pkg::DIV_STG-1:0]        h_valid;
  carry_t [lav_pkg::DIV_STG-1:0]        h_cr;
  logic   [lav_pkg::DIV_STG-1:0][lav_pkg::SQ_Q_W-1:0] h_n;
  lav_pkg::dv_t [lav_pkg::DIV_STG-1:0][2:0] h_dv;

  lav_pkg::rot_t [2:0]                  q_s;

  localparam logic [lav_pkg::SHW-1:0] TOP = lav_pkg::SHW'(lav_pkg::NORM_W - 1);

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      a_mag_next[i] = in_vec[i][lav_pkg::VEC_W-1] ? lav_pkg::MAG_W'(-in_vec[i])
                                                  : lav_pkg::MAG_W'(in_vec[i]);
    end
  end

  always_comb begin
    or_all = a_mag[0] | a_mag[1] | a_mag[2];
    p_next = '0;
    for (int i = 0; i < lav_pkg::MAG_W; i++) begin
      if (or_all[i]) begin
        p_next = lav_pkg::SHW'(i);
      end
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (b_p >= TOP) begin
        m_next[i] = lav_pkg::NORM_W'(b_mag[i] >> (b_p - TOP));
      end else begin
        m_next[i] = lav_pkg::NORM_W'(b_mag[i] << (TOP - b_p));
      end
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      q_s[i] = lav_pkg::ROT_W'(h_dv[lav_pkg::DIV_STG-1][i].q);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid   <= 1'b0;
      b_valid   <= 1'b0;
      c_valid   <= 1'b0;
      d_valid   <= 1'b0;
      e_valid   <= 1'b0;
      f_valid   <= '0;
      g_valid   <= 1'b0;
      h_valid   <= '0;
      out_valid <= 1'b0;
    end else if (en) begin
      a_valid   <= in_valid;
      b_valid   <= a_valid;
      c_valid   <= b_valid;
      d_valid   <= c_valid;
      e_valid   <= d_valid;
      f_valid   <= {f_valid[lav_pkg::SQ_STG-2:0], e_valid};
      g_valid   <= f_valid[lav_pkg::SQ_STG-1];
      h_valid   <= {h_valid[lav_pkg::DIV_STG-2:0], g_valid};
      out_valid <= h_valid[lav_pkg::DIV_STG-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_side <= in_side;
      a_mag  <= a_mag_next;
      for (int i = 0; i < 3; i++) begin
        a_sgn[i] <= in_vec[i][lav_pkg::VEC_W-1];
      end

      b_side <= a_side;
      b_sgn  <= a_sgn;
      b_mag  <= a_mag;
      b_p    <= p_next;
      b_zero <= (or_all == '0);

      c_cr.side <= b_side;
      c_cr.sgn  <= b_sgn;
      c_cr.zero <= b_zero;
      c_cr.m    <= m_next;

      d_cr <= c_cr;
      for (int i = 0; i < 3; i++) begin
        d_sq[i] <= c_cr.m[i] * c_cr.m[i];
      end

      e_cr <= d_cr;
      e_x  <= lav_pkg::SQ_X_W'(lav_pkg::SUM_W'(d_sq[0]) + lav_pkg::SUM_W'(d_sq[1])
                               + lav_pkg::SUM_W'(d_sq[2]));

      f_cr[0] <= e_cr;
      f_sq[0] <= lav_pkg::sqrt_step2('{x: e_x, rem: '0, root: '0});
      for (int k = 1; k < lav_pkg::SQ_STG; k++) begin
        f_cr[k] <= f_cr[k-1];
        f_sq[k] <= lav_pkg::sqrt_step2(f_sq[k-1]);
      end

      g_cr <= f_cr[lav_pkg::SQ_STG-1];
      g_n  <= f_sq[lav_pkg::SQ_STG-1].root;
      for (int i = 0; i < 3; i++) begin
        g_d[i] <= (lav_pkg::DIVD_W'(f_cr[lav_pkg::SQ_STG-1].m[i]) << lav_pkg::FRAC_BITS)
                + lav_pkg::DIVD_W'(f_sq[lav_pkg::SQ_STG-1].root >> 1);
      end

      h_cr[0] <= g_cr;
      h_n[0]  <= g_n;
      for (int i = 0; i < 3; i++) begin
        h_dv[0][i] <= lav_pkg::div_step2('{rem: lav_pkg::DR_W'(g_d[i] >> lav_pkg::DIV_N),
                                           d: g_d[i][lav_pkg::DIV_N-1:0], q: '0}, g_n);
      end
      for (int k = 1; k < lav_pkg::DIV_STG; k++) begin
        h_cr[k] <= h_cr[k-1];
        h_n[k]  <= h_n[k-1];
        for (int i = 0; i < 3; i++) begin
          h_dv[k][i] <= lav_pkg::div_step2(h_dv[k-1][i], h_n[k-1]);
        end
      end

      out_side <= h_cr[lav_pkg::DIV_STG-1].side;
      out_ok   <= !h_cr[lav_pkg::DIV_STG-1].zero;
      for (int i = 0; i < 3; i++) begin
        if (h_cr[lav_pkg::DIV_STG-1].zero) begin
          out_vec[i] <= '0;
        end else if (h_cr[lav_pkg::DIV_STG-1].sgn[i]) begin
          out_vec[i] <= -q_s[i];
        end else begin
          out_vec[i] <= q_s[i];
        end
      end
    end
  end

endmodule

// ===== hdl/lav_cross.sv =====
// two-stage cross product of a wide vector with a unit vector
`timescale 1ns / 1ps
module lav_cross (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  en,
  input  logic                  in_valid,
  input  lav_pkg::in_t  [2:0]   a,
  input  lav_pkg::rot_t [2:0]   b,
  input  lav_pkg::side_t        in_side,
  output logic                  out_valid,
  output lav_pkg::vec_t [2:0]   out_vec,
  output lav_pkg::side_t        out_side
);

  logic                  p_valid;
  lav_pkg::side_t        p_side;
  lav_pkg::vec_t [5:0]   p;

  always_ff @(posedge clk) begin
    if (rst) begin
      p_valid   <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      p_valid   <= in_valid;
      out_valid <= p_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p_side <= in_side;
      p[0]   <= a[1] * b[2];
      p[1]   <= a[2] * b[1];
      p[2]   <= a[2] * b[0];
      p[3]   <= a[0] * b[2];
      p[4]   <= a[0] * b[1];
      p[5]   <= a[1] * b[0];

      out_side   <= p_side;
      out_vec[0] <= p[0] - p[1];
      out_vec[1] <= p[2] - p[3];
      out_vec[2] <= p[4] - p[5];
    end
  end

endmodule

// ===== hdl/lav_dot.sv =====
// translation column: negated dot products, rounded and saturated
`timescale 1ns / 1ps
module lav_dot (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       en,
  input  logic                       in_valid,
  input  lav_pkg::rot_t  [2:0][2:0]  in_rows,
  input  lav_pkg::in_t   [2:0]       eye,
  input  logic                       in_ok,
  output logic                       out_valid,
  output lav_pkg::rot_t  [2:0][2:0]  out_rows,
  output lav_pkg::tr_t   [2:0]       out_shift,
  output logic                       out_ok
);

  typedef logic signed [lav_pkg::DOT_W-1:0] dot_t;

  localparam dot_t HALF   = dot_t'(1) <<< (lav_pkg::FRAC_BITS - 1);
  localparam dot_t TR_MAX = (dot_t'(1) <<< (lav_pkg::TR_W - 1)) - dot_t'(1);
  localparam dot_t TR_MIN = -(dot_t'(1) <<< (lav_pkg::TR_W - 1));

  logic                              p_valid;
  logic                              p_ok;
  lav_pkg::rot_t [2:0][2:0]          p_rows;
  lav_pkg::vec_t [2:0][2:0]          p;
  dot_t          [2:0]               q;

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      q[r] = (HALF - (dot_t'(p[r][0]) + dot_t'(p[r][1]) + dot_t'(p[r][2])))
             >>> lav_pkg::FRAC_BITS;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      p_valid   <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      p_valid   <= in_valid;
      out_valid <= p_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p_ok   <= in_ok;
      p_rows <= in_rows;
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 3; c++) begin
          p[r][c] <= in_rows[r][c] * eye[c];
        end
      end

      out_ok   <= p_ok;
      out_rows <= p_rows;
      for (int r = 0; r < 3; r++) begin
        if (q[r] > TR_MAX) begin
          out_shift[r] <= lav_pkg::TR_W'(TR_MAX);
        end else if (q[r] < TR_MIN) begin
          out_shift[r] <= lav_pkg::TR_W'(TR_MIN);
        end else begin
          out_shift[r] <= lav_pkg::TR_W'(q[r]);
        end
      end
    end
  end

endmodule
